@@ hdl/lrc_pkg.sv @@
// shared types and constants for the clipping line rasterizer
`default_nettype none
package lrc_pkg;

  localparam int COORD_BITS      = 12;
  localparam int BYTES_PER_PIXEL = 4;
  localparam int DIM_BITS        = 11;
  localparam int PITCH_BITS      = 15;
  localparam int OFFSET_BITS     = 25;
  localparam int COLOR_BITS      = 32;
  localparam int ERR_BITS        = COORD_BITS + 2;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = PITCH_BITS;

  localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = DIM_BITS'(480);
  localparam logic [PITCH_BITS-1:0] PITCH_RESET  = PITCH_BITS'(2560);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SURFACE_WIDTH  = 2'd0,
    CFG_SURFACE_HEIGHT = 2'd1,
    CFG_ROW_PITCH      = 2'd2
  } lrc_cfg_idx_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } lrc_kind_t;

  typedef struct packed {
    logic                         kind;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        pixel_color;
  } lrc_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [OFFSET_BITS-1:0]       byte_offset;
    logic [COLOR_BITS-1:0]        out_color;
    logic                         on_screen;
    logic                         last_pixel;
  } lrc_out_t;

  // current pixel of the line held by the stepper
  typedef struct packed {
    logic                         active;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0]        color;
    logic                         last;
  } lrc_cur_t;

endpackage
`default_nettype wire

@@ hdl/lrc_stepper.sv @@
// bresenham line state: endpoint load and one step per request
`default_nettype none
module lrc_stepper
  import lrc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire logic    step,
  input  wire lrc_in_t item,
  output lrc_cur_t     cur
);

  localparam int DW = COORD_BITS + 1;
  localparam int EW = ERR_BITS + 1;

  logic                         active_r, active_nxt;
  logic signed [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [COORD_BITS-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [COORD_BITS-1:0]        adx_r, adx_nxt, ady_r, ady_nxt;
  logic                         xneg_r, xneg_nxt, yneg_r, yneg_nxt;
  logic signed [ERR_BITS-1:0]   err_r, err_nxt;
  logic [COLOR_BITS-1:0]        color_r, color_nxt;

  logic signed [DW-1:0] ddx, ddy;
  logic [DW-1:0]        ddx_abs, ddy_abs;
  logic signed [EW-1:0] err_w, e2, dx_w, dy_w, err_step;
  logic                 x_move, y_move, last;

  // load-time deltas
  always_comb begin
    ddx     = DW'(item.end_x) - DW'(item.start_x);
    ddy     = DW'(item.end_y) - DW'(item.start_y);
    ddx_abs = ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
    ddy_abs = ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
  end

  // one step of the error term
  always_comb begin
    err_w    = EW'(err_r);
    e2       = err_w <<< 1;
    dx_w     = $signed({{(EW-COORD_BITS){1'b0}}, adx_r});
    dy_w     = $signed({{(EW-COORD_BITS){1'b0}}, ady_r});
    x_move   = e2 > -dy_w;
    y_move   = e2 < dx_w;
    err_step = err_w - (x_move ? dy_w : EW'(0)) + (y_move ? dx_w : EW'(0));
    last     = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);
  end

  always_comb begin
    active_nxt = active_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    adx_nxt    = adx_r;
    ady_nxt    = ady_r;
    xneg_nxt   = xneg_r;
    yneg_nxt   = yneg_r;
    err_nxt    = err_r;
    color_nxt  = color_r;
    if (load) begin
      active_nxt = 1'b1;
      cur_x_nxt  = item.start_x;
      cur_y_nxt  = item.start_y;
      tgt_x_nxt  = item.end_x;
      tgt_y_nxt  = item.end_y;
      adx_nxt    = ddx_abs[COORD_BITS-1:0];
      ady_nxt    = ddy_abs[COORD_BITS-1:0];
      xneg_nxt   = ddx[DW-1] || (ddx == '0);
      yneg_nxt   = ddy[DW-1] || (ddy == '0);
      err_nxt    = $signed(ERR_BITS'(ddx_abs) - ERR_BITS'(ddy_abs));
      color_nxt  = item.pixel_color;
    end else if (step && active_r) begin
      if (last) begin
        active_nxt = 1'b0;
      end else begin
        err_nxt = err_step[ERR_BITS-1:0];
        if (x_move) begin
          cur_x_nxt = xneg_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1);
        end
        if (y_move) begin
          cur_y_nxt = yneg_r ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      tgt_x_r  <= '0;
      tgt_y_r  <= '0;
      adx_r    <= '0;
      ady_r    <= '0;
      xneg_r   <= 1'b0;
      yneg_r   <= 1'b0;
      err_r    <= '0;
      color_r  <= '0;
    end else begin
      active_r <= active_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      tgt_x_r  <= tgt_x_nxt;
      tgt_y_r  <= tgt_y_nxt;
      adx_r    <= adx_nxt;
      ady_r    <= ady_nxt;
      xneg_r   <= xneg_nxt;
      yneg_r   <= yneg_nxt;
      err_r    <= err_nxt;
      color_r  <= color_nxt;
    end
  end

  assign cur.active = active_r;
  assign cur.x      = cur_x_r;
  assign cur.y      = cur_y_r;
  assign cur.color  = color_r;
  assign cur.last   = last;

endmodule
`default_nettype wire

@@ hdl/line_rasterizer_with_clip_top.sv @@
// top level of the clipping bresenham line rasterizer
`default_nettype none
// Line rasterizer with clipping and frame-buffer addressing. A load transfer
// (kind 0) takes two signed endpoints and a color and starts a new line,
// replacing any line in progress; it gives no result. Each step transfer
// (kind 1) gives the current pixel of the line and advances one bresenham
// step toward the second endpoint; after the pixel flagged last_pixel the
// line goes inactive and further steps give nothing. Pixels outside the
// configured surface are still given with on_screen low and byte_offset 0,
// so the frame-buffer write can be dropped. byte_offset is y*row_pitch + 4*x
// modulo 2^25. The line state advances at the edge that takes the step, and
// the pixel address (one 11x15 multiply and an add) is formed from the state
// registers straight into the result register, so a pixel comes out the cycle
// after its step, and one transfer per cycle is sustained while the output is
// not stalled. The input stalls only while a result sits in the result
// register and the output is stalled. Configuration is written through cfg_we,
// cfg_index and cfg_wdata while the block is idle; index 3 is ignored.
module line_rasterizer_with_clip_top
  import lrc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire lrc_in_t                  in_data,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output lrc_out_t                      out_data,
  // configuration writes
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int PROD_BITS = DIM_BITS + PITCH_BITS;

  // configuration registers
  logic [DIM_BITS-1:0]   width_r, height_r;
  logic [PITCH_BITS-1:0] pitch_r;

  // handshake and result register
  logic     accept, do_load, do_step, out_load;
  logic     out_valid_r;
  lrc_out_t out_r, res;

  lrc_cur_t cur;

  // clip and address terms
  logic                   visible;
  logic [PROD_BITS-1:0]   row_off;
  logic [OFFSET_BITS-1:0] col_off, offset;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      pitch_r  <= PITCH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SURFACE_WIDTH:  width_r  <= cfg_wdata[DIM_BITS-1:0];
        CFG_SURFACE_HEIGHT: height_r <= cfg_wdata[DIM_BITS-1:0];
        CFG_ROW_PITCH:      pitch_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // result register is free when empty or being drained this cycle
  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = !out_load;
  assign accept   = in_valid && !in_stall;
  assign do_load  = accept && (in_data.kind == KIND_LOAD);
  assign do_step  = accept && (in_data.kind == KIND_STEP);

  lrc_stepper u_stepper (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (do_load),
    .step  (do_step),
    .item  (in_data),
    .cur   (cur)
  );

  // clip against the surface; negative coordinates are never visible
  always_comb begin
    visible = !cur.x[COORD_BITS-1] && !cur.y[COORD_BITS-1] &&
              (PROD_BITS'(cur.x[COORD_BITS-2:0]) < PROD_BITS'(width_r)) &&
              (PROD_BITS'(cur.y[COORD_BITS-2:0]) < PROD_BITS'(height_r));
    row_off = PROD_BITS'(cur.y[COORD_BITS-2:0]) * PROD_BITS'(pitch_r);
    col_off = OFFSET_BITS'(cur.x[COORD_BITS-2:0]) * OFFSET_BITS'(BYTES_PER_PIXEL);
    offset  = visible ? (row_off[OFFSET_BITS-1:0] + col_off) : '0;
  end

  always_comb begin
    res.pixel_x     = cur.x;
    res.pixel_y     = cur.y;
    res.byte_offset = offset;
    res.out_color   = cur.color;
    res.on_screen   = visible;
    res.last_pixel  = cur.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      // a step with no active line leaves the register empty
      out_valid_r <= do_step && cur.active;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ hdl/lrc_checker.sv @@
// port-level checks for the line rasterizer and their bind
`default_nettype none
module lrc_checker
  import lrc_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire lrc_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire lrc_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a load transfer never produces a pixel
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.kind == KIND_LOAD) |=> !out_valid)
    else $error("result after load");

  // off-screen pixels carry a zero offset
  a_offscreen_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.on_screen |-> out_data.byte_offset == '0)
    else $error("off-screen pixel with nonzero offset");

  // visible pixels have nonnegative coordinates
  a_onscreen_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.on_screen |->
      !out_data.pixel_x[COORD_BITS-1] && !out_data.pixel_y[COORD_BITS-1])
    else $error("visible pixel with negative coordinate");

endmodule

bind line_rasterizer_with_clip_top lrc_checker u_lrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

@@ tb/tb_line_rasterizer_with_clip_top.sv @@
// self-checking testbench for the clipping bresenham line rasterizer
`default_nettype none
module tb_line_rasterizer_with_clip_top;
  import lrc_pkg::*;

  // index 3 has no register behind it, writes there must change nothing
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  lrc_in_t                  in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  lrc_out_t                 out_data;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_SURFACE_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  line_rasterizer_with_clip_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // items waiting to be driven, and pixels the line stepper must still give
  lrc_in_t  pending_q[$];
  lrc_out_t pixel_q[$];

  int errors = 0;
  bit calm = 1'b0;   // while set neither side idles or stalls

  // predictor copy of the surface registers
  logic [DIM_BITS-1:0]   surf_w    = WIDTH_RESET;
  logic [DIM_BITS-1:0]   surf_h    = HEIGHT_RESET;
  logic [PITCH_BITS-1:0] row_step  = PITCH_RESET;

  // predictor copy of the line being walked
  bit                           drawing   = 1'b0;
  logic signed [COORD_BITS-1:0] pos_x     = '0;
  logic signed [COORD_BITS-1:0] pos_y     = '0;
  logic signed [COORD_BITS-1:0] goal_x    = '0;
  logic signed [COORD_BITS-1:0] goal_y    = '0;
  logic [COORD_BITS-1:0]        span_x    = '0;
  logic [COORD_BITS-1:0]        span_y    = '0;
  bit                           neg_x     = 1'b0;
  bit                           neg_y     = 1'b0;
  logic signed [ERR_BITS-1:0]   err_acc   = '0;
  logic [COLOR_BITS-1:0]        line_rgba = '0;

  // apply one transfer to the predicted line state, queue the pixel it gives
  task automatic advance_line(input lrc_in_t item);
    int       dx, dy, e2, err_next;
    bit       seen, at_end;
    lrc_out_t px;
    if (item.kind == KIND_LOAD) begin
      // a load always starts over, whatever line was in progress
      pos_x     = item.start_x;
      pos_y     = item.start_y;
      goal_x    = item.end_x;
      goal_y    = item.end_y;
      line_rgba = item.pixel_color;
      dx        = int'(goal_x) - int'(pos_x);
      dy        = int'(goal_y) - int'(pos_y);
      span_x    = COORD_BITS'((dx < 0) ? -dx : dx);
      span_y    = COORD_BITS'((dy < 0) ? -dy : dy);
      neg_x     = !(pos_x < goal_x);
      neg_y     = !(pos_y < goal_y);
      err_acc   = ERR_BITS'(int'(span_x) - int'(span_y));
      drawing   = 1'b1;
    end else if (drawing) begin
      // clip test against the surface, the offset only counts when visible
      seen = (pos_x >= 0) && (pos_y >= 0) &&
             (int'(pos_x) < int'(surf_w)) && (int'(pos_y) < int'(surf_h));
      at_end = (pos_x == goal_x) && (pos_y == goal_y);
      px.pixel_x     = pos_x;
      px.pixel_y     = pos_y;
      px.byte_offset = seen ? OFFSET_BITS'(longint'(pos_y) * longint'(row_step) +
                                          BYTES_PER_PIXEL * longint'(pos_x)) : '0;
      px.out_color   = line_rgba;
      px.on_screen   = seen;
      px.last_pixel  = at_end;
      pixel_q.push_back(px);
      if (at_end) begin
        drawing = 1'b0;
      end else begin
        // one bresenham step, both axes judged on the same doubled error
        e2       = 2 * int'(err_acc);
        err_next = int'(err_acc);
        if (e2 > -int'(span_y)) begin
          err_next -= int'(span_y);
          pos_x = COORD_BITS'(neg_x ? int'(pos_x) - 1 : int'(pos_x) + 1);
        end
        if (e2 < int'(span_x)) begin
          err_next += int'(span_x);
          pos_y = COORD_BITS'(neg_y ? int'(pos_y) - 1 : int'(pos_y) + 1);
        end
        err_acc = ERR_BITS'(err_next);
      end
    end
    // a step with no line gives nothing and changes nothing
  endtask

  // driver: takes the next pending item when the previous one has transferred
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        advance_line(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n)
      out_stall <= 1'b0;
    else
      out_stall <= !calm && ($urandom_range(0, 99) < 12);
  end

  task automatic flag_field(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  lrc_out_t want_px;

  // monitor: every pixel transfer is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, got %h", $time, out_data);
      end else begin
        want_px = pixel_q.pop_front();
        flag_field("pixel_x", 32'(want_px.pixel_x), 32'(out_data.pixel_x));
        flag_field("pixel_y", 32'(want_px.pixel_y), 32'(out_data.pixel_y));
        flag_field("byte_offset", 32'(want_px.byte_offset), 32'(out_data.byte_offset));
        flag_field("out_color", want_px.out_color, out_data.out_color);
        flag_field("on_screen", 32'(want_px.on_screen), 32'(out_data.on_screen));
        flag_field("last_pixel", 32'(want_px.last_pixel), 32'(out_data.last_pixel));
      end
    end
  end

  task automatic queue_load(input int sx, input int sy, input int ex, input int ey,
                            input logic [COLOR_BITS-1:0] rgba);
    lrc_in_t item;
    item.kind        = KIND_LOAD;
    item.start_x     = COORD_BITS'(sx);
    item.start_y     = COORD_BITS'(sy);
    item.end_x       = COORD_BITS'(ex);
    item.end_y       = COORD_BITS'(ey);
    item.pixel_color = rgba;
    pending_q.push_back(item);
  endtask

  // step requests carry junk in the endpoint fields, the block must ignore it
  task automatic queue_steps(input int n);
    lrc_in_t item;
    repeat (n) begin
      item      = $bits(lrc_in_t)'({$urandom, $urandom, $urandom});
      item.kind = KIND_STEP;
      pending_q.push_back(item);
    end
  endtask

  function automatic int clamp_coord(input int v);
    if (v < -(1 << (COORD_BITS - 1)))
      return -(1 << (COORD_BITS - 1));
    if (v > (1 << (COORD_BITS - 1)) - 1)
      return (1 << (COORD_BITS - 1)) - 1;
    return v;
  endfunction

  // coordinate around the visible span so lines cross the clip edges
  function automatic int near_edge(input int lim);
    return clamp_coord(int'($urandom_range(0, lim + 15)) - 8);
  endfunction

  // block idle: nothing queued, nothing in flight, no pixel outstanding
  task automatic drain();
    while (pending_q.size() != 0 || in_valid || pixel_q.size() != 0)
      @(negedge clk);
    // a trailing load gives no pixel, let it settle
    repeat (4) @(posedge clk);
  endtask

  // write all three surface registers back to back, upper data bits are junk
  // for the 11-bit registers and must be dropped
  task automatic apply_surface(input int w, input int h, input int p,
                               input bit poke_unused);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SURFACE_WIDTH;
    cfg_wdata <= {4'($urandom), DIM_BITS'(w)};
    @(posedge clk);
    cfg_index <= CFG_SURFACE_HEIGHT;
    cfg_wdata <= {4'($urandom), DIM_BITS'(h)};
    @(posedge clk);
    cfg_index <= CFG_ROW_PITCH;
    cfg_wdata <= PITCH_BITS'(p);
    if (poke_unused) begin
      @(posedge clk);
      cfg_index <= CFG_UNUSED_IDX;
      cfg_wdata <= PITCH_BITS'($urandom);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    surf_w   = DIM_BITS'(w);
    surf_h   = DIM_BITS'(h);
    row_step = PITCH_BITS'(p);
  endtask

  // mostly short lines near the surface walked to their end, some cut short
  // by a reload, some wild lines across the whole coordinate range
  task automatic random_lines(input int quota);
    int made, pick, sx, sy, ex, ey, len, n;
    made = 0;
    while (made < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        sx = near_edge(int'(surf_w));
        sy = near_edge(int'(surf_h));
        if ($urandom_range(0, 9) == 0) begin
          ex = clamp_coord(sx + int'($urandom_range(0, 400)) - 200);
          ey = clamp_coord(sy + int'($urandom_range(0, 400)) - 200);
        end else begin
          ex = clamp_coord(sx + int'($urandom_range(0, 24)) - 12);
          ey = clamp_coord(sy + int'($urandom_range(0, 24)) - 12);
        end
        len = ((ex > sx) ? ex - sx : sx - ex);
        if (((ey > sy) ? ey - sy : sy - ey) > len)
          len = (ey > sy) ? ey - sy : sy - ey;
        len += 1;
        n = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, len))
                                        : len + int'($urandom_range(0, 2));
        queue_load(sx, sy, ex, ey, $urandom);
        queue_steps(n);
        made += 1 + n;
      end else if (pick < 92) begin
        n = $urandom_range(0, 20);
        queue_load(int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                   int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
                   $urandom);
        queue_steps(n);
        made += 1 + n;
      end else begin
        // loose steps, often landing on no active line
        queue_steps($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset surface
    queue_steps(2);                                      // nothing loaded yet
    queue_load(5, 7, 5, 7, 32'hA5A5_A5A5);               // single point line
    queue_steps(2);                                      // second step finds no line
    queue_load(-2048, -2048, 2047, 2047, 32'hFFFF_FFFF);
    queue_steps(2);
    queue_load(2047, -2048, -2048, 2047, 32'h0000_0000); // replaces the line in flight
    queue_steps(2);
    queue_load(638, 478, 641, 481, 32'h1234_5678);       // walks off the bottom right
    queue_steps(5);
    queue_load(2, 0, 0, 5, 32'h8000_0001);               // steep, x decreasing
    queue_steps(7);
    drain();

    // smallest surface and pitch
    apply_surface(1, 1, 4, 1'b0);
    random_lines(300);
    drain();

    // largest surface and pitch, so the offset wraps; no idling here
    apply_surface(2047, 2047, 32767, 1'b1);
    calm = 1'b1;
    random_lines(400);
    drain();
    calm = 1'b0;

    // empty surface: nothing may be on screen
    apply_surface(0, 0, $urandom_range(4, 16384), 1'b0);
    random_lines(150);
    drain();

    // moderate random surface
    apply_surface($urandom_range(16, 200), $urandom_range(16, 200),
                  $urandom_range(4, 16384), 1'b1);
    random_lines(550);
    drain();

    // back to the reset values, sender held off halfway until all pixels are in
    apply_surface(int'(WIDTH_RESET), int'(HEIGHT_RESET), int'(PITCH_RESET), 1'b0);
    random_lines(275);
    drain();
    random_lines(275);
    drain();

    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("tb_line_rasterizer_with_clip_top: done, clean");
    end else begin
      $display("tb_line_rasterizer_with_clip_top: done, errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(8 * 300000);
    $display("tb_line_rasterizer_with_clip_top: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
